### rtl/core/dual_scan_lcd_refresh_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LCD refresh block.
// ----------------------------------------------------------------------------
`ifndef DUAL_SCAN_LCD_REFRESH_DEFINES_SVH
`define DUAL_SCAN_LCD_REFRESH_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DSL_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsl assertion failed");

// next-cycle implication
`define DSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsl assertion failed");

`else

`define DSL_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define DSL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// Types, codes and widths shared by the dual-scan LCD refresh block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsl_pkg;

  localparam int DISPLAY_WIDTH_PIXELS_DEF = 240;
  localparam int HALF_LINES_DEF           = 32;

  localparam int FUNC_W     = 2;
  localparam int X_W        = 9;
  localparam int Y_W        = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int BRIGHT_W   = 7;

  // widths cover the full parameter range (64 half lines, 64 byte columns)
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int KB_W   = 9;
  localparam int LIM_W  = 15;
  localparam int PROD_W = 16;

  localparam int PWM_SCALE = 100;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS       = 1'd1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_TICK
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic               in_range;
    logic               lower;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [2:0]         bit_sel;
    logic               value;
    logic               frame;
    logic               polarity;
    logic               bl_enable;
    logic               bl_restart;
    logic [KB_W-1:0]    k_base;
    logic [LIM_W-1:0]   limit;
  } dsl_cmd_t;

  typedef struct packed {
    logic       kind;
    logic       read_bit;
    logic [7:0] upper_byte;
    logic [7:0] lower_byte;
    logic       frame_flag;
    logic       m_phase;
    logic       backlight_out;
    logic       last_column;
  } dsl_result_t;

endpackage

`default_nettype wire

### rtl/core/dsl_ram.sv
// ----------------------------------------------------------------------------
// dsl_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/dsl_fifo.sv
// ----------------------------------------------------------------------------
// dsl_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               din,
  input  wire logic                           pop,
  output logic      [WIDTH-1:0]               dout,
  output logic                                empty,
  output logic                                full,
  output logic      [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dsl_front.sv
// ----------------------------------------------------------------------------
// dsl_front
// Takes input beats, range-checks pixels, tracks scan line and polarity,
// and hands commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_front #(
  parameter int DISPLAY_WIDTH_PIXELS = dsl_pkg::DISPLAY_WIDTH_PIXELS_DEF,
  parameter int HALF_LINES           = dsl_pkg::HALF_LINES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [dsl_pkg::FUNC_W-1:0]    func,
  input  wire logic [dsl_pkg::X_W-1:0]       x_pos,
  input  wire logic [dsl_pkg::Y_W-1:0]       y_pos,
  input  wire logic                          pixel_value,
  input  wire logic                          backlight_enable,
  input  wire logic [dsl_pkg::BRIGHT_W-1:0]  brightness_percent,
  input  wire logic                          cmd_full,
  input  wire logic                          clearing,
  output logic                               cmd_push,
  output dsl_pkg::dsl_cmd_t                  cmd
);

  import dsl_pkg::*;

  localparam int NUM_COLS = (DISPLAY_WIDTH_PIXELS + 7) / 8;
  localparam int HALF_W   = DISPLAY_WIDTH_PIXELS / 2;

  logic [ROW_W-1:0] scan_line;
  logic             polarity;
  logic             accept;
  logic             x_ok;
  logic             y_ok;
  logic             y_lower;
  logic             pol_new;

  assign full    = cmd_full || clearing;
  assign accept  = push && !full;
  assign x_ok    = {1'b0, x_pos} < (X_W+1)'(DISPLAY_WIDTH_PIXELS);
  assign y_ok    = {1'b0, y_pos} < (Y_W+1)'(2 * HALF_LINES);
  assign y_lower = {1'b0, y_pos} >= (Y_W+1)'(HALF_LINES);
  assign pol_new = (scan_line == '0) ? !polarity : polarity;

  always_comb begin
    cmd          = '0;
    cmd_push     = 1'b0;
    cmd.in_range = x_ok && y_ok;
    cmd.lower    = y_lower;
    cmd.row      = y_lower ? ROW_W'(y_pos - Y_W'(HALF_LINES)) : ROW_W'(y_pos);
    cmd.col      = x_pos[X_W-1:3];
    cmd.bit_sel  = x_pos[2:0];
    cmd.value    = pixel_value;
    unique case (func)
      FUNC_WRITE: begin
        cmd.op   = OP_WRITE;
        cmd_push = accept;
      end
      FUNC_READ: begin
        cmd.op   = OP_READ;
        cmd_push = accept;
      end
      FUNC_TICK: begin
        cmd.op         = OP_TICK;
        cmd.row        = scan_line;
        cmd.frame      = (scan_line == ROW_W'(1));
        cmd.polarity   = pol_new;
        cmd.bl_enable  = backlight_enable;
        cmd.bl_restart = (scan_line[2:0] == 3'd0);
        cmd.k_base     = KB_W'(scan_line[2:0] * NUM_COLS);
        cmd.limit      = LIM_W'(brightness_percent * HALF_W);
        cmd_push       = accept;
      end
      default: begin
        cmd.op = OP_WRITE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_line <= '0;
      polarity  <= 1'b1;
    end else if (accept && func == FUNC_TICK) begin
      polarity  <= pol_new;
      scan_line <= (scan_line == ROW_W'(HALF_LINES - 1)) ? '0 : scan_line + ROW_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/dsl_back.sv
// ----------------------------------------------------------------------------
// dsl_back
// Two half-panel frame banks; clears after reset, does pixel read-modify-write
// and reads; a tick streams one column pair per cycle while results have room.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_scan_lcd_refresh_defines.svh"

module dsl_back #(
  parameter int DISPLAY_WIDTH_PIXELS = dsl_pkg::DISPLAY_WIDTH_PIXELS_DEF,
  parameter int HALF_LINES           = dsl_pkg::HALF_LINES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cmd_valid,
  input  wire dsl_pkg::dsl_cmd_t                       cmd,
  output logic                                         cmd_pop,
  output logic                                         clearing,
  input  wire logic [$clog2(dsl_pkg::RES_DEPTH+1)-1:0] res_count,
  output logic                                         res_push,
  output dsl_pkg::dsl_result_t                         res
);

  import dsl_pkg::*;

  localparam int NUM_COLS   = (DISPLAY_WIDTH_PIXELS + 7) / 8;
  localparam int BANK_DEPTH = HALF_LINES * NUM_COLS;
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_SCAN
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] line_base;
  logic              scan_frame;
  logic              scan_pol;
  logic [KB_W-1:0]   scan_kbase;
  logic [LIM_W-1:0]  scan_limit;
  logic              bl_level;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic              wr_value;
  logic              wr_lower;

  logic              infl_valid;
  logic              infl_kind;
  logic              infl_in_range;
  logic              infl_lower;
  logic [7:0]        infl_mask;
  logic              infl_frame;
  logic              infl_pol;
  logic              infl_bl;
  logic              infl_last;

  logic              space;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        cmd_mask;
  logic              last_col;
  logic [KB_W-1:0]   k_idx;
  logic              over;
  logic              lvl_col;
  logic              issue_scan;
  logic [7:0]        rd_up;
  logic [7:0]        rd_lo;
  logic [7:0]        wr_old;
  logic [7:0]        wr_data;
  logic              we_up;
  logic              we_lo;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  assign clearing   = (state == ST_CLEAR);
  assign space      = (res_count + CNT_W'(infl_valid)) < CNT_W'(RES_DEPTH);
  assign row_base   = ADDR_W'(cmd.row * NUM_COLS);
  assign pix_addr   = row_base + ADDR_W'(cmd.col);
  assign cmd_mask   = 8'h80 >> cmd.bit_sel;
  assign last_col   = (col == COL_W'(NUM_COLS - 1));
  assign k_idx      = scan_kbase + KB_W'(col);
  assign over       = PROD_W'(k_idx * PWM_SCALE) > PROD_W'(scan_limit);
  assign lvl_col    = bl_level && !over;
  assign issue_scan = (state == ST_SCAN) && space;
  assign rd_addr    = (state == ST_SCAN) ? line_base + ADDR_W'(col) : pix_addr;
  assign wr_old     = wr_lower ? rd_lo : rd_up;
  assign wr_data    = wr_value ? (wr_old | wr_mask) : (wr_old & ~wr_mask);

  always_comb begin
    cmd_pop = 1'b0;
    if (state == ST_IDLE && cmd_valid) begin
      cmd_pop = (cmd.op != OP_READ) || space;
    end
  end

  always_comb begin
    we_up     = 1'b0;
    we_lo     = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = wr_data;
    if (state == ST_CLEAR) begin
      we_up     = 1'b1;
      we_lo     = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_WR_MOD) begin
      we_up = !wr_lower;
      we_lo = wr_lower;
    end
  end

  dsl_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_up (
    .clk   (clk),
    .we    (we_up),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_up)
  );

  dsl_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_lo (
    .clk   (clk),
    .we    (we_lo),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_lo)
  );

  always_comb begin
    res      = '0;
    res_push = infl_valid;
    if (infl_kind) begin
      res.kind          = 1'b1;
      res.upper_byte    = rd_up;
      res.lower_byte    = rd_lo;
      res.frame_flag    = infl_frame;
      res.m_phase       = infl_pol;
      res.backlight_out = infl_bl;
      res.last_column   = infl_last;
    end else begin
      res.read_bit = infl_in_range && |((infl_lower ? rd_lo : rd_up) & infl_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      bl_level   <= 1'b0;
      infl_valid <= 1'b0;
    end else begin
      infl_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(BANK_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op)
              OP_WRITE: begin
                wr_addr  <= pix_addr;
                wr_mask  <= cmd_mask;
                wr_value <= cmd.value;
                wr_lower <= cmd.lower;
                if (cmd.in_range) begin
                  state <= ST_WR_MOD;
                end
              end
              OP_READ: begin
                infl_valid    <= 1'b1;
                infl_kind     <= 1'b0;
                infl_in_range <= cmd.in_range;
                infl_lower    <= cmd.lower;
                infl_mask     <= cmd_mask;
              end
              OP_TICK: begin
                line_base  <= row_base;
                col        <= '0;
                scan_frame <= cmd.frame;
                scan_pol   <= cmd.polarity;
                scan_kbase <= cmd.k_base;
                scan_limit <= cmd.limit;
                bl_level   <= cmd.bl_enable && (cmd.bl_restart || bl_level);
                state      <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WR_MOD: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (issue_scan) begin
            infl_valid <= 1'b1;
            infl_kind  <= 1'b1;
            infl_frame <= scan_frame;
            infl_pol   <= scan_pol;
            infl_bl    <= lvl_col;
            infl_last  <= last_col;
            bl_level   <= lvl_col;
            col        <= col + COL_W'(1);
            if (last_col) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DSL_ASSERT_HOLDS(a_res_room, clk, rst, res_push, res_count < CNT_W'(RES_DEPTH))
  `DSL_ASSERT_HOLDS(a_no_pop_clear, clk, rst, state == ST_CLEAR, !cmd_pop)
  `DSL_ASSERT_HOLDS(a_we_source, clk, rst, we_up || we_lo, state == ST_CLEAR || state == ST_WR_MOD)
  `DSL_ASSERT_NEXT(a_scan_end, clk, rst, issue_scan && last_col, state == ST_IDLE && infl_last)

endmodule

`default_nettype wire

### rtl/core/dual_scan_lcd_refresh.sv
// ----------------------------------------------------------------------------
// dual_scan_lcd_refresh
// Frame buffer and line scanner for a dual-scan passive graphic LCD.
//
//   channel   handshake          payload
//   input     push / full        func, x_pos, y_pos, pixel_value
//   result    empty / pop        kind, read_bit, upper_byte, lower_byte,
//                                frame_flag, m_phase, backlight_out, last_column
//   config    cfg_wr_en          cfg_index, cfg_data
//
// A line tick gives ceil(DISPLAY_WIDTH_PIXELS/8) results, one per cycle while
// the result queue has room; the back end scans the line's columns in ST_SCAN,
// reading one byte pair per column, and returns to ST_IDLE after the last.
// Both half-panel banks are read together.
// A pixel write does a read-modify-write via ST_WR_MOD; a read does not.
// After reset the store is cleared, all HALF_LINES*ceil(DISPLAY_WIDTH_PIXELS/8)
// byte addresses in both banks, with full held high.
// A stalled result side fills a 4-beat result queue, then a 2-beat command
// queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_scan_lcd_refresh_defines.svh"

module dual_scan_lcd_refresh #(
  parameter int DISPLAY_WIDTH_PIXELS = dsl_pkg::DISPLAY_WIDTH_PIXELS_DEF,
  parameter int HALF_LINES           = dsl_pkg::HALF_LINES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [dsl_pkg::FUNC_W-1:0]      func,
  input  wire logic [dsl_pkg::X_W-1:0]         x_pos,
  input  wire logic [dsl_pkg::Y_W-1:0]         y_pos,
  input  wire logic                            pixel_value,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 kind,
  output logic                                 read_bit,
  output logic      [7:0]                      upper_byte,
  output logic      [7:0]                      lower_byte,
  output logic                                 frame_flag,
  output logic                                 m_phase,
  output logic                                 backlight_out,
  output logic                                 last_column,
  input  wire logic                            cfg_wr_en,
  input  wire logic [dsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import dsl_pkg::*;

  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  logic                  backlight_enable;
  logic [BRIGHT_W-1:0]   brightness_percent;

  dsl_cmd_t              front_cmd;
  dsl_cmd_t              head_cmd;
  logic                  cmd_push;
  logic                  cmd_pop;
  logic                  cmd_empty;
  logic                  cmd_full;
  logic [CMD_CNT_W-1:0]  cmd_count;
  logic                  clearing;

  dsl_result_t           back_res;
  dsl_result_t           head_res;
  logic                  res_push;
  logic                  res_full;
  logic [RES_CNT_W-1:0]  res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_enable   <= 1'b0;
      brightness_percent <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BACKLIGHT_ENABLE: backlight_enable   <= cfg_data[0];
        CFG_BRIGHTNESS:       brightness_percent <= cfg_data;
      endcase
    end
  end

  dsl_front #(
    .DISPLAY_WIDTH_PIXELS (DISPLAY_WIDTH_PIXELS),
    .HALF_LINES           (HALF_LINES)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .func               (func),
    .x_pos              (x_pos),
    .y_pos              (y_pos),
    .pixel_value        (pixel_value),
    .backlight_enable   (backlight_enable),
    .brightness_percent (brightness_percent),
    .cmd_full           (cmd_full),
    .clearing           (clearing),
    .cmd_push           (cmd_push),
    .cmd                (front_cmd)
  );

  dsl_fifo #(.WIDTH($bits(dsl_cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (front_cmd),
    .pop   (cmd_pop),
    .dout  (head_cmd),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  dsl_back #(
    .DISPLAY_WIDTH_PIXELS (DISPLAY_WIDTH_PIXELS),
    .HALF_LINES           (HALF_LINES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty && cmd_count != '0),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (back_res)
  );

  dsl_fifo #(.WIDTH($bits(dsl_result_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .pop   (pop),
    .dout  (head_res),
    .empty (empty),
    .full  (res_full),
    .count (res_count)
  );

  assign kind          = head_res.kind;
  assign read_bit      = head_res.read_bit;
  assign upper_byte    = head_res.upper_byte;
  assign lower_byte    = head_res.lower_byte;
  assign frame_flag    = head_res.frame_flag;
  assign m_phase       = head_res.m_phase;
  assign backlight_out = head_res.backlight_out;
  assign last_column   = head_res.last_column;

  `DSL_ASSERT_HOLDS(a_res_no_overflow, clk, rst, res_push, !res_full)

endmodule

`default_nettype wire
